// ===== rtl/core/atp_pkg.sv =====
package atp_pkg;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int FRAC_BITS = 8;
    localparam int SQ_W      = 32;
    localparam int RAD_W     = 48;
    localparam int ROOT_W    = 24;
    localparam int REM_W     = 27;
    localparam int CORDIC_W  = 28;
    localparam int ACC_W     = 32;
    localparam int TAB_LEN   = 24;

    localparam logic [ACC_W-1:0] HALF_TURN = 32'h8000_0000;

    localparam logic [ACC_W-1:0] ATAN_TAB [0:TAB_LEN-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef logic signed [IN_W-1:0]     t_sample;
    typedef logic signed [CORDIC_W-1:0] t_vec_coord;

    typedef struct packed {
        t_sample x;
        t_sample y;
        t_sample z;
    } t_acc_vec;

endpackage

// ===== rtl/core/atp_isqrt.sv =====
module atp_isqrt (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [atp_pkg::SQ_W-1:0]  i_sq,
    input  atp_pkg::t_acc_vec         i_vec,
    output logic [atp_pkg::ROOT_W-1:0] o_root,
    output atp_pkg::t_acc_vec         o_vec
);
    import atp_pkg::*;

    logic [RAD_W-1:0]  r_n   [0:ROOT_W-1];
    logic [REM_W-1:0]  r_rem [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_q   [0:ROOT_W-1];
    t_acc_vec          r_vec [0:ROOT_W-1];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic [RAD_W-1:0]  s_n;
        logic [REM_W-1:0]  s_rem;
        logic [ROOT_W-1:0] s_q;
        t_acc_vec          s_vec;
        logic [REM_W-1:0]  s_rem_sh;
        logic [REM_W-1:0]  s_trial;
        logic              s_take;

        if (k == 0) begin : g_first
            assign s_n   = {i_sq, {(RAD_W-SQ_W){1'b0}}};
            assign s_rem = '0;
            assign s_q   = '0;
            assign s_vec = i_vec;
        end else begin : g_next
            assign s_n   = r_n[k-1];
            assign s_rem = r_rem[k-1];
            assign s_q   = r_q[k-1];
            assign s_vec = r_vec[k-1];
        end

        assign s_rem_sh = {s_rem[REM_W-3:0], s_n[RAD_W-1 -: 2]};
        assign s_trial  = REM_W'({s_q, 2'b01});
        assign s_take   = (s_rem_sh >= s_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k]   <= {s_n[RAD_W-3:0], 2'b00};
                r_rem[k] <= s_take ? (s_rem_sh - s_trial) : s_rem_sh;
                r_q[k]   <= {s_q[ROOT_W-2:0], s_take};
                r_vec[k] <= s_vec;
            end
        end
    end

    assign o_root = r_q[ROOT_W-1];
    assign o_vec  = r_vec[ROOT_W-1];

endmodule

// ===== rtl/core/atp_cordic.sv =====
module atp_cordic #(
    parameter int STEPS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  atp_pkg::t_vec_coord        i_x,
    input  atp_pkg::t_vec_coord        i_y,
    output logic [atp_pkg::ACC_W-1:0]  o_acc
);
    import atp_pkg::*;

    t_vec_coord       r_x    [0:STEPS];
    t_vec_coord       r_y    [0:STEPS];
    logic [ACC_W-1:0] r_acc  [0:STEPS];
    logic             r_zero [0:STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x[CORDIC_W-1]) begin
                r_x[0]   <= -i_x;
                r_y[0]   <= -i_y;
                r_acc[0] <= HALF_TURN;
            end else begin
                r_x[0]   <= i_x;
                r_y[0]   <= i_y;
                r_acc[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[k+1] <= r_zero[k];
                if (r_y[k][CORDIC_W-1]) begin
                    r_x[k+1]   <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1]   <= r_y[k] + (r_x[k] >>> k);
                    r_acc[k+1] <= r_acc[k] - ATAN_TAB[k];
                end else begin
                    r_x[k+1]   <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1]   <= r_y[k] - (r_x[k] >>> k);
                    r_acc[k+1] <= r_acc[k] + ATAN_TAB[k];
                end
            end
        end
    end

    assign o_acc = r_zero[STEPS] ? '0 : r_acc[STEPS];

endmodule

// ===== rtl/core/accel_tilt_angles_core.sv =====
// Roll and pitch from one three-axis accelerometer sample, in binary angle
// units (2^(ANGLE_BITS-1) is pi). Fully pipelined: a sample is taken every
// cycle unless the output is held. The pipeline has two squaring and
// summing stages, one stage per result bit of the 24-bit square root, and
// one stage per CORDIC micro-rotation plus its entry stage, then the output
// register. Roll and pitch run through two CORDIC pipelines side by side.
// When the output is held, the whole pipeline holds and o_ready drops.
module accel_tilt_angles_core #(
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [atp_pkg::IN_W-1:0]       i_acc_x,
    input  logic signed [atp_pkg::IN_W-1:0]       i_acc_y,
    input  logic signed [atp_pkg::IN_W-1:0]       i_acc_z,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [atp_pkg::OUT_W-1:0]      o_roll_angle,
    output logic signed [atp_pkg::OUT_W-1:0]      o_pitch_angle
);
    import atp_pkg::*;

    localparam int LAT = 2 + ROOT_W + CORDIC_STEPS + 2;

    logic                 en;
    logic [LAT-1:0]       r_vld;

    logic signed [31:0]   c_py;
    logic signed [31:0]   c_pz;
    logic [SQ_W-2:0]      r_sq_y;
    logic [SQ_W-2:0]      r_sq_z;
    t_acc_vec             r_vec_a;
    logic [SQ_W-1:0]      r_sq;
    t_acc_vec             r_vec_b;

    logic [ROOT_W-1:0]    root;
    t_acc_vec             vec_c;
    t_vec_coord           roll_x;
    t_vec_coord           roll_y;
    t_vec_coord           pitch_x;
    t_vec_coord           pitch_y;
    logic [ACC_W-1:0]     roll_acc;
    logic [ACC_W-1:0]     pitch_acc;

    logic [ACC_W:0]       roll_sum;
    logic [ACC_W:0]       pitch_sum;
    logic [ANGLE_BITS-1:0] roll_ang;
    logic [ANGLE_BITS-1:0] pitch_ang;

    logic [OUT_W-1:0]     r_roll;
    logic [OUT_W-1:0]     r_pitch;

    assign en      = ~r_vld[LAT-1] | i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    assign c_py = i_acc_y * i_acc_y;
    assign c_pz = i_acc_z * i_acc_z;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_y  <= c_py[SQ_W-2:0];
            r_sq_z  <= c_pz[SQ_W-2:0];
            r_vec_a <= '{x: i_acc_x, y: i_acc_y, z: i_acc_z};
            r_sq    <= {1'b0, r_sq_y} + {1'b0, r_sq_z};
            r_vec_b <= r_vec_a;
        end
    end

    atp_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sq   (r_sq),
        .i_vec  (r_vec_b),
        .o_root (root),
        .o_vec  (vec_c)
    );

    assign roll_x  = CORDIC_W'(vec_c.z) <<< FRAC_BITS;
    assign roll_y  = -(CORDIC_W'(vec_c.y) <<< FRAC_BITS);
    assign pitch_x = CORDIC_W'(signed'({1'b0, root}));
    assign pitch_y = CORDIC_W'(vec_c.x) <<< FRAC_BITS;

    atp_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_roll (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (roll_x),
        .i_y   (roll_y),
        .o_acc (roll_acc)
    );

    atp_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_pitch (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (pitch_x),
        .i_y   (pitch_y),
        .o_acc (pitch_acc)
    );

    assign roll_sum  = {1'b0, roll_acc + HALF_TURN}
                     + ((ACC_W+1)'(1) << (ACC_W - 1 - ANGLE_BITS));
    assign pitch_sum = {1'b0, ACC_W'(0) - pitch_acc}
                     + ((ACC_W+1)'(1) << (ACC_W - 1 - ANGLE_BITS));
    assign roll_ang  = roll_sum[ACC_W-1 -: ANGLE_BITS];
    assign pitch_ang = pitch_sum[ACC_W-1 -: ANGLE_BITS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll  <= OUT_W'(roll_ang);
            r_pitch <= OUT_W'(pitch_ang);
        end
    end

    assign o_roll_angle  = r_roll;
    assign o_pitch_angle = r_pitch;

endmodule
